@@ hdl/heq_pkg.sv @@
// shared types and constants of the explicit heat equation solver
`timescale 1ns / 1ps

package heq_pkg;

	localparam int SAMPLE_W   = 32;
	localparam int INDEX_W    = 6;
	localparam int RATE_W     = 24;
	localparam int STEPS_W    = 16;
	localparam int RATE_SHIFT = 24;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_RATE_COEFF = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP_COUNT = 2'd1;

	localparam logic [RATE_W-1:0]  RATE_RESET  = 24'd60566;
	localparam logic [STEPS_W-1:0] STEPS_RESET = 16'd1000;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample_value;
		logic                       row_last;
	} item_word_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] result_value;
		logic [INDEX_W-1:0]         point_index;
		logic                       result_last;
		logic                       overflow_flag;
	} result_word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_DRAIN,
		ST_EMIT,
		ST_FLUSH
	} state_t;

endpackage

@@ hdl/heat_equation_explicit_solver.sv @@
// top level of the explicit (ftcs) one-dimensional heat equation solver
`timescale 1ns / 1ps

// Usage
//   item channel: a word (sample_value, row_last) is taken at a rising edge with
//   start high and busy low. Samples are written into the grid memory in order, one
//   per cycle; samples past POINTS are dropped and set the overflow flag of the row.
//   The word with row_last set starts the run and raises busy.
//   run: step_count time steps, each a sweep over the grid memory that reads one
//   point per cycle and writes the new interior values behind the read pointer.
//   Each step reads the n points of the row, then drains the read / laplacian / multiply
//   pipeline before the next step reads point one again. With fewer than three points
//   or zero steps the sweep is skipped.
//   result channel: the row comes out as n words, one per cycle on strobe; the first
//   follows the state register moving to emit and its read being registered. Each is
//   valid for exactly that one cycle and the receiver cannot hold it off. busy falls
//   after the final word.
//   config channel: cfg_valid / cfg_ready with cfg_index and cfg_data; ready only
//   while idle. Unknown indexes are ignored.
//   reset: arst_n clears the control state and loads the default rate and step count;
//   the grid memory is not cleared, only loaded entries are read.

module heat_equation_explicit_solver #(
	parameter int POINTS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  heq_pkg::item_word_t           item,
	output logic                          strobe,
	output heq_pkg::result_word_t         result,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [heq_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [heq_pkg::CFG_DATA_W-1:0] cfg_data
);
	import heq_pkg::*;

	localparam int IW = $clog2(POINTS);
	localparam int CW = $clog2(POINTS + 1);
	localparam logic signed [35:0] SUM_MAX = 36'sh07FFFFFFF;
	localparam logic signed [35:0] SUM_MIN = 36'shF80000000;

	// configuration registers
	logic [RATE_W-1:0]  rate_q;
	logic [STEPS_W-1:0] step_cnt_q;

	// control state
	state_t            state_q, state_d;
	logic [CW-1:0]     count_q;
	logic              dropped_q;
	logic [STEPS_W-1:0] steps_done_q;
	logic [IW-1:0]     ptr_q;

	// pipeline control
	logic              rv_s1, em_s1, cv_s2, cv_s3;
	logic [IW-1:0]     tag_s1, wa_s2, wa_s3;

	// pipeline payload
	logic signed [31:0] rd_q;
	logic signed [31:0] left_q, mid_q;
	logic signed [33:0] lap_s2;
	logic signed [31:0] mid_s2, mid_s3;
	logic signed [58:0] prod_s3;

	// grid memory
	logic [31:0] grid_mem [POINTS];

	logic              accept, rd_en, at_last, pipe_empty, run_trivial, room;
	logic [IW-1:0]     rd_addr;
	logic [CW-1:0]     last_idx, n_next;
	logic              we;
	logic [IW-1:0]     wa;
	logic [31:0]       wd;
	logic signed [33:0] r_ext, m_ext, l_ext;
	logic signed [24:0] rate_s;
	logic signed [34:0] delta;
	logic signed [35:0] sum;
	logic signed [31:0] sat_val;

	assign accept     = start && !busy;
	assign room       = count_q < CW'(POINTS);
	assign n_next     = room ? count_q + CW'(1) : count_q;
	assign run_trivial = (n_next < CW'(3)) || (step_cnt_q == '0);
	assign last_idx   = count_q - CW'(1);
	assign at_last    = (CW'(ptr_q) == last_idx);
	assign pipe_empty = !rv_s1 && !cv_s2 && !cv_s3;
	assign cfg_ready  = !busy;

	// next state and sequencing outputs
	always_comb begin
		state_d = state_q;
		busy    = 1'b1;
		rd_en   = 1'b0;
		rd_addr = ptr_q;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (accept && item.row_last) begin
					state_d = run_trivial ? ST_EMIT : ST_SWEEP;
				end
			end
			ST_SWEEP: begin
				rd_en = 1'b1;
				if (at_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				// wait for the last writes of this step before point one is read again
				if (pipe_empty) begin
					state_d = (steps_done_q + STEPS_W'(1) == step_cnt_q) ? ST_EMIT : ST_SWEEP;
				end
			end
			ST_EMIT: begin
				rd_en = 1'b1;
				if (at_last) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q     <= RATE_RESET;
			step_cnt_q <= STEPS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_RATE_COEFF: rate_q     <= cfg_data[RATE_W-1:0];
				CFG_STEP_COUNT: step_cnt_q <= cfg_data[STEPS_W-1:0];
				default: ;
			endcase
		end
	end

	// counters and pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			dropped_q    <= 1'b0;
			steps_done_q <= '0;
			ptr_q        <= '0;
			rv_s1        <= 1'b0;
			em_s1        <= 1'b0;
			cv_s2        <= 1'b0;
			cv_s3        <= 1'b0;
			tag_s1       <= '0;
		end else begin
			if (state_q == ST_IDLE && accept) begin
				if (room) begin
					count_q <= count_q + CW'(1);
				end else begin
					dropped_q <= 1'b1;
				end
			end
			if (state_q == ST_FLUSH) begin
				count_q      <= '0;
				dropped_q    <= 1'b0;
				steps_done_q <= '0;
			end
			if (state_q == ST_DRAIN && pipe_empty) begin
				steps_done_q <= steps_done_q + STEPS_W'(1);
			end
			if (rd_en) begin
				ptr_q <= at_last ? '0 : ptr_q + IW'(1);
			end
			rv_s1  <= rd_en && (state_q == ST_SWEEP);
			em_s1  <= rd_en && (state_q == ST_EMIT);
			tag_s1 <= rd_addr;
			// a point is computed once its right neighbour has arrived
			cv_s2  <= rv_s1 && (tag_s1 >= IW'(2));
			cv_s3  <= cv_s2;
		end
	end

	// datapath: window of old values, laplacian, product
	assign r_ext  = 34'(rd_q);
	assign m_ext  = 34'(mid_q);
	assign l_ext  = 34'(left_q);
	assign rate_s = $signed({1'b0, rate_q});

	always_ff @(posedge clk) begin
		if (rv_s1) begin
			left_q <= mid_q;
			mid_q  <= rd_q;
			lap_s2 <= r_ext - (m_ext <<< 1) + l_ext;
			mid_s2 <= mid_q;
			wa_s2  <= tag_s1 - IW'(1);
		end
		prod_s3 <= 59'(lap_s2) * 59'(rate_s);
		mid_s3  <= mid_s2;
		wa_s3   <= wa_s2;
	end

	// floor shift and saturating add
	always_comb begin
		delta = 35'(prod_s3 >>> RATE_SHIFT);
		sum   = 36'(mid_s3) + 36'(delta);
		if (sum > SUM_MAX) begin
			sat_val = SUM_MAX[31:0];
		end else if (sum < SUM_MIN) begin
			sat_val = SUM_MIN[31:0];
		end else begin
			sat_val = sum[31:0];
		end
	end

	// memory write port: load while idle, write-back while running
	always_comb begin
		if (state_q == ST_IDLE) begin
			we = accept && room;
			wa = count_q[IW-1:0];
			wd = item.sample_value;
		end else begin
			we = cv_s3;
			wa = wa_s3;
			wd = sat_val;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			grid_mem[wa] <= wd;
		end
		if (rd_en) begin
			rd_q <= grid_mem[rd_addr];
		end
	end

	// result word
	assign strobe               = em_s1;
	assign result.result_value  = rd_q;
	assign result.point_index   = INDEX_W'(tag_s1);
	assign result.result_last   = (CW'(tag_s1) == last_idx);
	assign result.overflow_flag = dropped_q;

	// checks
	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> busy)
		else $error("result strobe while idle");

	a_end_fixed: assert property (@(posedge clk) disable iff (!arst_n)
		(cv_s3 && state_q != ST_IDLE) |-> (wa_s3 != '0 && CW'(wa_s3) != last_idx))
		else $error("write-back to a fixed end point");

	a_read_ahead: assert property (@(posedge clk) disable iff (!arst_n)
		(cv_s3 && rd_en) |-> (rd_addr > wa_s3))
		else $error("read of an entry at or behind the write-back pointer");

	a_flush_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH) |-> (strobe && result.result_last))
		else $error("row end not on final result");

	a_idle_after_row: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && result.result_last) |=> (!busy && count_q == '0))
		else $error("block not ready after the row was emitted");

endmodule
